[rtl/hgt_pkg.sv]
// ----------------------------------------------------------------------------
// Height grid triangulator package
// Shared widths, register indexes, record layouts and the size clamp.
// ----------------------------------------------------------------------------
package hgt_pkg;

	localparam int ROW_W     = 10;
	localparam int COL_W     = 10;
	localparam int VN_W      = 21;
	localparam int HT_W      = 32;
	localparam int SIZE_W    = 11;
	localparam int CFG_IDX_W = 2;

	localparam logic [SIZE_W-1:0] MAX_ROWS = 11'd1024;
	localparam logic [SIZE_W-1:0] MAX_COLS = 11'd1024;
	localparam logic [SIZE_W-1:0] MIN_SIZE = 11'd2;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_LVL_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NODATA   = 2'd2;

	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_TRI    = 1'b1;

	localparam logic [1:0] IDX_SAMPLE = 2'd0;
	localparam logic [1:0] IDX_TRI1   = 2'd1;
	localparam logic [1:0] IDX_TRI2   = 2'd2;

	typedef struct packed {
		logic [SIZE_W-1:0] num_rows;
		logic [SIZE_W-1:0] num_cols;
		logic signed [HT_W-1:0] nodata;
	} cfg_t;

	typedef struct packed {
		logic                   valid;
		logic signed [HT_W-1:0] height;
		logic [VN_W-1:0]        vnum;
	} sample_t;

	typedef struct packed {
		sample_t          e;
		logic [VN_W-1:0]  vn_a;
		logic [VN_W-1:0]  vn_b;
		logic [VN_W-1:0]  vn_d;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             eog;
		logic             tri_pair;
		logic             split_ae;
	} job_t;

	typedef struct packed {
		logic                   kind;
		logic                   valid_res;
		logic [COL_W-1:0]       col_pos;
		logic [ROW_W-1:0]       row_pos;
		logic signed [HT_W-1:0] height_out;
		logic [VN_W-1:0]        corner_a;
		logic [VN_W-1:0]        corner_b;
		logic [VN_W-1:0]        corner_c;
		logic                   last_of_run;
		logic                   end_of_grid;
	} res_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] r;
		if (v < MIN_SIZE) begin
			r = MIN_SIZE;
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

[rtl/hgt_front.sv]
// ----------------------------------------------------------------------------
// Height grid triangulator front end
// Accepts heights, numbers vertices, keeps the column store and classifies
// each quad, then hands one job per item to the queue.
// ----------------------------------------------------------------------------
module hgt_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hgt_pkg::cfg_t                 cfg,
	input  logic                          push,
	output logic                          full,
	input  logic signed [hgt_pkg::HT_W-1:0] height,
	input  logic [hgt_pkg::Q_LVL_W-1:0]   q_level,
	output logic                          q_push,
	output hgt_pkg::job_t                 q_job
);

	logic [hgt_pkg::SIZE_W-1:0] rows;
	logic [hgt_pkg::SIZE_W-1:0] cols;
	logic                       accept;
	logic                       last_row;
	logic                       last_col;
	hgt_pkg::sample_t           cur;
	logic [hgt_pkg::VN_W-1:0]   vnum_next;

	logic [hgt_pkg::ROW_W-1:0]  row_q;
	logic [hgt_pkg::COL_W-1:0]  col_q;
	logic [hgt_pkg::VN_W-1:0]   vcnt_q;
	hgt_pkg::sample_t           corner_q;
	hgt_pkg::sample_t           above_q;

	hgt_pkg::sample_t           col_mem [0:hgt_pkg::MAX_ROWS-1];

	logic                       v_s1;
	hgt_pkg::sample_t           rd_s1;
	hgt_pkg::sample_t           e_s1;
	logic [hgt_pkg::COL_W-1:0]  col_s1;
	logic [hgt_pkg::ROW_W-1:0]  row_s1;
	logic                       eog_s1;
	logic                       quad_s1;

	logic signed [hgt_pkg::HT_W:0] diff_ae;
	logic signed [hgt_pkg::HT_W:0] diff_bd;
	logic [hgt_pkg::HT_W:0]        mag_ae;
	logic [hgt_pkg::HT_W:0]        mag_bd;
	logic                          tri_s1;

	logic                       v_s2;
	hgt_pkg::job_t              job_s2;
	logic [hgt_pkg::HT_W:0]     mag_ae_s2;
	logic [hgt_pkg::HT_W:0]     mag_bd_s2;

	assign rows = hgt_pkg::clamp_size(cfg.num_rows, hgt_pkg::MAX_ROWS);
	assign cols = hgt_pkg::clamp_size(cfg.num_cols, hgt_pkg::MAX_COLS);

	assign full = (q_level + hgt_pkg::Q_LVL_W'(v_s1) + hgt_pkg::Q_LVL_W'(v_s2))
		>= hgt_pkg::Q_LVL_W'(hgt_pkg::Q_DEPTH);
	assign accept = push && !full;

	assign last_row = ({1'b0, row_q} + 11'd1) >= rows;
	assign last_col = ({1'b0, col_q} + 11'd1) >= cols;

	assign vnum_next  = vcnt_q + 21'd1;
	assign cur.valid  = height > cfg.nodata;
	assign cur.height = height;
	assign cur.vnum   = cur.valid ? vnum_next : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			vcnt_q   <= '0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			corner_q <= '0;
			above_q  <= '0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			if (accept) begin
				if (cur.valid) begin
					vcnt_q <= vnum_next;
				end
				if (last_row) begin
					row_q <= '0;
					if (last_col) begin
						col_q  <= '0;
						vcnt_q <= '0;
					end else begin
						col_q <= col_q + 10'd1;
					end
				end else begin
					row_q <= row_q + 10'd1;
				end
			end
			if (v_s1) begin
				corner_q <= rd_s1;
				above_q  <= e_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_mem[row_q] <= cur;
			rd_s1          <= col_mem[row_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			e_s1    <= cur;
			col_s1  <= col_q;
			row_s1  <= row_q;
			eog_s1  <= last_row && last_col;
			quad_s1 <= (row_q != '0) && (col_q != '0);
		end
	end

	assign diff_ae = {corner_q.height[hgt_pkg::HT_W-1], corner_q.height}
		- {e_s1.height[hgt_pkg::HT_W-1], e_s1.height};
	assign diff_bd = {above_q.height[hgt_pkg::HT_W-1], above_q.height}
		- {rd_s1.height[hgt_pkg::HT_W-1], rd_s1.height};
	assign mag_ae = diff_ae[hgt_pkg::HT_W] ? 33'(-diff_ae) : 33'(diff_ae);
	assign mag_bd = diff_bd[hgt_pkg::HT_W] ? 33'(-diff_bd) : 33'(diff_bd);
	assign tri_s1 = quad_s1 && corner_q.valid && above_q.valid && rd_s1.valid
		&& e_s1.valid;

	always_ff @(posedge clk) begin
		if (v_s1) begin
			job_s2.e        <= e_s1;
			job_s2.vn_a     <= corner_q.vnum;
			job_s2.vn_b     <= above_q.vnum;
			job_s2.vn_d     <= rd_s1.vnum;
			job_s2.col      <= col_s1;
			job_s2.row      <= row_s1;
			job_s2.eog      <= eog_s1;
			job_s2.tri_pair <= tri_s1;
			job_s2.split_ae <= 1'b0;
			mag_ae_s2       <= mag_ae;
			mag_bd_s2       <= mag_bd;
		end
	end

	always_comb begin
		q_job          = job_s2;
		q_job.split_ae = mag_ae_s2 < mag_bd_s2;
	end

	assign q_push = v_s2;

endmodule

[rtl/hgt_queue.sv]
// ----------------------------------------------------------------------------
// Height grid triangulator job queue
// Four-entry first-in first-out queue between front and back end.
// ----------------------------------------------------------------------------
module hgt_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  hgt_pkg::job_t               din,
	input  logic                        pop,
	output hgt_pkg::job_t               dout,
	output logic                        empty,
	output logic [hgt_pkg::Q_LVL_W-1:0] level
);

	hgt_pkg::job_t               slot_q [0:hgt_pkg::Q_DEPTH-1];
	logic [hgt_pkg::Q_PTR_W-1:0] wr_q;
	logic [hgt_pkg::Q_PTR_W-1:0] rd_q;
	logic [hgt_pkg::Q_LVL_W-1:0] level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 2'd1;
			end
			if (pop) begin
				rd_q <= rd_q + 2'd1;
			end
			level_q <= level_q + hgt_pkg::Q_LVL_W'(push) - hgt_pkg::Q_LVL_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= din;
		end
	end

	assign dout  = slot_q[rd_q];
	assign empty = (level_q == '0);
	assign level = level_q;

endmodule

[rtl/hgt_back.sv]
// ----------------------------------------------------------------------------
// Height grid triangulator back end
// Expands each job into a sample record and, when its quad is fully valid, two
// triangle records, and holds the oldest one in the output register.
// ----------------------------------------------------------------------------
module hgt_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  hgt_pkg::job_t job,
	output logic          q_pop,
	input  logic          pop,
	output logic          empty,
	output hgt_pkg::res_t res
);

	logic [1:0]    idx_q;
	logic          out_v_q;
	hgt_pkg::res_t res_q;
	hgt_pkg::res_t nxt;
	logic          load;

	always_comb begin
		nxt             = '0;
		nxt.col_pos     = job.col;
		nxt.row_pos     = job.row;
		nxt.end_of_grid = job.eog;
		case (idx_q)
			hgt_pkg::IDX_TRI1: begin
				nxt.kind     = hgt_pkg::KIND_TRI;
				nxt.corner_a = job.vn_a;
				nxt.corner_b = job.vn_d;
				nxt.corner_c = job.split_ae ? job.vn_b : job.e.vnum;
			end
			hgt_pkg::IDX_TRI2: begin
				nxt.kind        = hgt_pkg::KIND_TRI;
				nxt.corner_a    = job.split_ae ? job.vn_d : job.vn_a;
				nxt.corner_b    = job.e.vnum;
				nxt.corner_c    = job.vn_b;
				nxt.last_of_run = 1'b1;
			end
			default: begin
				nxt.kind        = hgt_pkg::KIND_SAMPLE;
				nxt.valid_res   = job.e.valid;
				nxt.height_out  = job.e.height;
				nxt.corner_a    = job.e.vnum;
				nxt.last_of_run = !job.tri_pair;
			end
		endcase
	end

	assign load  = !q_empty && (!out_v_q || pop);
	assign q_pop = load && nxt.last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= hgt_pkg::IDX_SAMPLE;
			out_v_q <= 1'b0;
		end else begin
			if (load) begin
				out_v_q <= 1'b1;
				idx_q   <= nxt.last_of_run ? hgt_pkg::IDX_SAMPLE : idx_q + 2'd1;
			end else if (pop) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= nxt;
		end
	end

	assign empty = !out_v_q;
	assign res   = res_q;

endmodule

[rtl/height_grid_triangulator.sv]
// ----------------------------------------------------------------------------
// Height grid triangulator
// Numbers valid grid samples and splits each fully valid quad along the
// diagonal with the larger height difference into two triangles.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  input     in         push / full         height
//  result    out        empty / pop         kind .. end_of_grid
//  config    in         cfg_valid / ready   cfg_index, cfg_data
//
// An item passes the front-end s1 and s2 registers and then the queue; its
// sample record is loaded into the result register once that register is free.
// The result register sends one record per cycle while pop is held and the queue has a job,
// one record for a lone sample and three when a quad closes, and this sets the sustained rate.
// Reset clears counters and control; the 1024-entry column store has no clearing pass.
// When the queue plus the items in the front end reach four, full rises.
// ----------------------------------------------------------------------------
module height_grid_triangulator (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic signed [hgt_pkg::HT_W-1:0]   height,
	output logic                              empty,
	input  logic                              pop,
	output logic                              kind,
	output logic                              valid_res,
	output logic [hgt_pkg::COL_W-1:0]         col_pos,
	output logic [hgt_pkg::ROW_W-1:0]         row_pos,
	output logic signed [hgt_pkg::HT_W-1:0]   height_out,
	output logic [hgt_pkg::VN_W-1:0]          corner_a,
	output logic [hgt_pkg::VN_W-1:0]          corner_b,
	output logic [hgt_pkg::VN_W-1:0]          corner_c,
	output logic                              last_of_run,
	output logic                              end_of_grid,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hgt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hgt_pkg::HT_W-1:0]          cfg_data
);

	hgt_pkg::cfg_t               cfg_q;
	logic                        q_push;
	logic                        q_pop;
	logic                        q_empty;
	logic [hgt_pkg::Q_LVL_W-1:0] q_level;
	hgt_pkg::job_t               q_din;
	hgt_pkg::job_t               q_dout;
	hgt_pkg::res_t               res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.num_rows <= 11'd1024;
			cfg_q.num_cols <= 11'd1024;
			cfg_q.nodata   <= -32'sd2559744;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				hgt_pkg::REG_NUM_ROWS: cfg_q.num_rows <= cfg_data[hgt_pkg::SIZE_W-1:0];
				hgt_pkg::REG_NUM_COLS: cfg_q.num_cols <= cfg_data[hgt_pkg::SIZE_W-1:0];
				hgt_pkg::REG_NODATA:   cfg_q.nodata   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	hgt_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.push    (push),
		.full    (full),
		.height  (height),
		.q_level (q_level),
		.q_push  (q_push),
		.q_job   (q_din)
	);

	hgt_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty),
		.level  (q_level)
	);

	hgt_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.job     (q_dout),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	assign kind        = res.kind;
	assign valid_res   = res.valid_res;
	assign col_pos     = res.col_pos;
	assign row_pos     = res.row_pos;
	assign height_out  = res.height_out;
	assign corner_a    = res.corner_a;
	assign corner_b    = res.corner_b;
	assign corner_c    = res.corner_c;
	assign last_of_run = res.last_of_run;
	assign end_of_grid = res.end_of_grid;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> (q_level < hgt_pkg::Q_LVL_W'(hgt_pkg::Q_DEPTH)))
		else $error("Job queue written while full.");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("Job queue read while empty.");

	a_tri_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == hgt_pkg::KIND_TRI) |-> (!valid_res && height_out == '0))
		else $error("Triangle record carries sample fields.");

endmodule

[test/triangle_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Triangle checker
// Watches the sample, result and register channels of the height grid
// triangulator, predicts the sample and triangle records of every accepted
// height and compares each popped record with the oldest prediction.
// ----------------------------------------------------------------------------
module triangle_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	input  logic                              full,
	input  logic signed [hgt_pkg::HT_W-1:0]   height,
	input  logic                              empty,
	input  logic                              pop,
	input  logic                              kind,
	input  logic                              valid_res,
	input  logic [hgt_pkg::COL_W-1:0]         col_pos,
	input  logic [hgt_pkg::ROW_W-1:0]         row_pos,
	input  logic signed [hgt_pkg::HT_W-1:0]   height_out,
	input  logic [hgt_pkg::VN_W-1:0]          corner_a,
	input  logic [hgt_pkg::VN_W-1:0]          corner_b,
	input  logic [hgt_pkg::VN_W-1:0]          corner_c,
	input  logic                              last_of_run,
	input  logic                              end_of_grid,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [hgt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hgt_pkg::HT_W-1:0]          cfg_data,
	output int                                mismatches,
	output int                                pending,
	output logic [hgt_pkg::COL_W-1:0]         at_col,
	output int                                rows_covered
);
	import hgt_pkg::*;

	typedef struct packed {
		logic                   ok;
		logic signed [HT_W-1:0] h;
		logic [VN_W-1:0]        vn;
	} grid_pt_t;

	grid_pt_t               col_mem [0:1023];
	grid_pt_t               diag_prev;
	grid_pt_t               up_prev;
	logic [SIZE_W-1:0]      rows_reg;
	logic [SIZE_W-1:0]      cols_reg;
	logic signed [HT_W-1:0] floor_level;
	logic [ROW_W-1:0]       row_at;
	logic [COL_W-1:0]       col_at;
	logic [VN_W-1:0]        vtx_count;
	int                     covered;
	int                     fails = 0;
	res_t                   expected_records [$];

	function automatic int size_eff(input logic [SIZE_W-1:0] v, input logic [SIZE_W-1:0] top);
		if (v < MIN_SIZE) begin
			return int'(MIN_SIZE);
		end
		if (v > top) begin
			return int'(top);
		end
		return int'(v);
	endfunction

	task automatic compare_field(input string what, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			fails++;
			if (fails <= 40) begin
				$display("%0t %s: expected %h, actual %h", $time, what, want, got);
			end
		end
	endtask

	task automatic check_result();
		res_t want;
		if (expected_records.size() == 0) begin
			fails++;
			if (fails <= 40) begin
				$display("%0t unexpected result item: expected none, actual kind %0d row %0d col %0d",
					$time, kind, row_pos, col_pos);
			end
		end else begin
			want = expected_records.pop_front();
			compare_field("kind", 32'(want.kind), 32'(kind));
			compare_field("valid_res", 32'(want.valid_res), 32'(valid_res));
			compare_field("col_pos", 32'(want.col_pos), 32'(col_pos));
			compare_field("row_pos", 32'(want.row_pos), 32'(row_pos));
			compare_field("height_out", want.height_out, height_out);
			compare_field("corner_a", 32'(want.corner_a), 32'(corner_a));
			compare_field("corner_b", 32'(want.corner_b), 32'(corner_b));
			compare_field("corner_c", 32'(want.corner_c), 32'(corner_c));
			compare_field("last_of_run", 32'(want.last_of_run), 32'(last_of_run));
			compare_field("end_of_grid", 32'(want.end_of_grid), 32'(end_of_grid));
		end
	endtask

	task automatic triangulate(input logic signed [HT_W-1:0] hin);
		int       rows_e;
		int       cols_e;
		logic     lr;
		logic     lc;
		logic     eog;
		grid_pt_t cur;
		grid_pt_t a;
		grid_pt_t b;
		grid_pt_t d;
		res_t     rec;
		res_t     t1;
		res_t     t2;
		longint   diag_ae;
		longint   diag_bd;
		rows_e = size_eff(rows_reg, MAX_ROWS);
		cols_e = size_eff(cols_reg, MAX_COLS);
		lr = (int'(row_at) + 1 >= rows_e);
		lc = (int'(col_at) + 1 >= cols_e);
		eog = lr && lc;

		cur.h = hin;
		cur.ok = (hin > floor_level);
		cur.vn = '0;
		if (cur.ok) begin
			vtx_count = vtx_count + 1'b1;
			cur.vn = vtx_count;
		end

		rec = '0;
		rec.kind = KIND_SAMPLE;
		rec.valid_res = cur.ok;
		rec.col_pos = col_at;
		rec.row_pos = row_at;
		rec.height_out = hin;
		rec.corner_a = cur.vn;
		rec.end_of_grid = eog;

		a = diag_prev;
		b = up_prev;
		d = col_mem[row_at];

		if (row_at != '0 && col_at != '0 && a.ok && b.ok && d.ok && cur.ok) begin
			expected_records.push_back(rec);
			t1 = '0;
			t1.kind = KIND_TRI;
			t1.col_pos = col_at;
			t1.row_pos = row_at;
			t1.end_of_grid = eog;
			t2 = t1;
			t2.last_of_run = 1'b1;
			diag_ae = longint'($signed(a.h)) - longint'($signed(cur.h));
			diag_bd = longint'($signed(b.h)) - longint'($signed(d.h));
			if (diag_ae < 0) begin
				diag_ae = -diag_ae;
			end
			if (diag_bd < 0) begin
				diag_bd = -diag_bd;
			end
			if (diag_ae < diag_bd) begin
				t1.corner_a = a.vn;
				t1.corner_b = d.vn;
				t1.corner_c = b.vn;
				t2.corner_a = d.vn;
				t2.corner_b = cur.vn;
				t2.corner_c = b.vn;
			end else begin
				t1.corner_a = a.vn;
				t1.corner_b = d.vn;
				t1.corner_c = cur.vn;
				t2.corner_a = a.vn;
				t2.corner_b = cur.vn;
				t2.corner_c = b.vn;
			end
			expected_records.push_back(t1);
			expected_records.push_back(t2);
		end else begin
			rec.last_of_run = 1'b1;
			expected_records.push_back(rec);
		end

		diag_prev = d;
		col_mem[row_at] = cur;
		up_prev = cur;
		if (int'(row_at) + 1 > covered) begin
			covered = int'(row_at) + 1;
		end

		if (lr) begin
			row_at = '0;
			if (lc) begin
				col_at = '0;
				vtx_count = '0;
			end else begin
				col_at = col_at + 1'b1;
			end
		end else begin
			row_at = row_at + 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_reg = MAX_ROWS;
			cols_reg = MAX_COLS;
			floor_level = -32'sd2559744;
			foreach (col_mem[i]) begin
				col_mem[i] = '0;
			end
			diag_prev = '0;
			up_prev = '0;
			row_at = '0;
			col_at = '0;
			vtx_count = '0;
			covered = 0;
			expected_records.delete();
			mismatches <= fails;
			pending <= 0;
			at_col <= '0;
			rows_covered <= 0;
		end else begin
			if (pop && !empty) begin
				check_result();
			end
			if (push && !full) begin
				triangulate(height);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_NUM_ROWS: begin
						rows_reg = cfg_data[SIZE_W-1:0];
					end
					REG_NUM_COLS: begin
						cols_reg = cfg_data[SIZE_W-1:0];
					end
					REG_NODATA: begin
						floor_level = cfg_data;
					end
					default: begin
					end
				endcase
			end
			mismatches <= fails;
			pending <= expected_records.size();
			at_col <= col_at;
			rows_covered <= covered;
		end
	end

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Height grid triangulator testbench
// Drives height samples and register writes into the triangulator with random
// gaps and result stalls: a directed opening on edge heights, ties and size
// changes, then random grids of mostly valid heights around the nodata level.
// ----------------------------------------------------------------------------
module testbench;
	import hgt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int unsigned LIMIT = 500000;
	localparam int RANDOM_ITEMS = 330;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   push = 1'b0;
	logic                   full;
	logic signed [HT_W-1:0] height = '0;
	logic                   empty;
	logic                   pop = 1'b0;
	logic                   kind;
	logic                   valid_res;
	logic [COL_W-1:0]       col_pos;
	logic [ROW_W-1:0]       row_pos;
	logic signed [HT_W-1:0] height_out;
	logic [VN_W-1:0]        corner_a;
	logic [VN_W-1:0]        corner_b;
	logic [VN_W-1:0]        corner_c;
	logic                   last_of_run;
	logic                   end_of_grid;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [HT_W-1:0]        cfg_data = '0;

	int                     mismatches;
	int                     pending;
	logic [COL_W-1:0]       at_col;
	int                     rows_covered;

	logic [HT_W-1:0]        height_plan [$];
	logic signed [HT_W-1:0] floor_cur = -32'sd2559744;
	logic [HT_W-1:0]        last_height = '0;
	logic                   burst = 1'b0;
	logic                   pop_steady = 1'b0;
	int                     stall_left = 0;
	int unsigned            cycle_count = 0;

	height_grid_triangulator u_top (.*);

	triangle_checker u_checker (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			pop <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			pop <= 1'b1;
			if (!pop_steady && $urandom_range(0, 3) == 0) begin
				stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) :
					$urandom_range(1, 3);
			end
		end
	end

	function automatic int unsigned send_gap();
		int unsigned k;
		if (burst) begin
			return 0;
		end
		k = $urandom_range(0, 19);
		if (k < 12) begin
			return 0;
		end
		if (k < 18) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [HT_W-1:0] size_word(input logic [SIZE_W-1:0] v);
		return ($urandom() & 32'hFFFF_F800) | {21'd0, v};
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		int unsigned k;
		k = $urandom_range(0, 19);
		case (k)
			0: return 11'd0;
			1: return 11'd1;
			2: begin
				case ($urandom_range(0, 2))
					0: return 11'd1024;
					1: return 11'd1025;
					default: return 11'd2047;
				endcase
			end
			3, 4: return 11'($urandom_range(9, 40));
			default: return 11'($urandom_range(2, 8));
		endcase
	endfunction

	function automatic logic [HT_W-1:0] near_floor();
		longint v;
		v = longint'(floor_cur) + longint'($urandom_range(1, 4000));
		if (v > 64'sh7FFF_FFFF) begin
			v = 64'sh7FFF_FFFF;
		end
		return v[HT_W-1:0];
	endfunction

	function automatic logic [HT_W-1:0] random_height();
		int unsigned     k;
		logic [HT_W-1:0] h;
		k = $urandom_range(0, 99);
		if (k < 75) begin
			h = near_floor();
		end else if (k < 83) begin
			h = floor_cur - $urandom_range(0, 3);
		end else if (k < 92) begin
			h = $urandom();
		end else begin
			h = last_height;
		end
		last_height = h;
		return h;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [HT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) begin
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		if (idx == REG_NODATA) begin
			floor_cur = data;
		end
		@(posedge clk);
	endtask

	task automatic feed();
		int unsigned g;
		while (height_plan.size() != 0) begin
			g = send_gap();
			if (g != 0) begin
				push <= 1'b0;
				repeat (g) @(posedge clk);
			end
			push <= 1'b1;
			height <= height_plan.pop_front();
			@(posedge clk);
			while (full) begin
				@(posedge clk);
			end
		end
		push <= 1'b0;
		@(posedge clk);
	endtask

	task automatic settle(input int extra);
		while (pending != 0) begin
			@(posedge clk);
		end
		repeat (extra) @(posedge clk);
	endtask

	initial begin
		int                random_sent;
		int                batch;
		logic [SIZE_W-1:0] size_pick;
		int unsigned       k;
		random_sent = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sizes below the minimum, lowest nodata level, tie on extreme heights.
		write_reg(REG_SPARE, $urandom());
		write_reg(REG_NUM_ROWS, size_word(11'd0));
		write_reg(REG_NUM_COLS, size_word(11'd1));
		write_reg(REG_NODATA, 32'h8000_0000);
		height_plan = '{32'h7FFF_FFFF, 32'h8000_0001, 32'h7FFF_FFFF, 32'h8000_0001,
			32'd0, 32'd100, 32'd200, 32'd5,
			32'h8000_0000, 32'd1, 32'd2, 32'd3};
		feed();

		// Highest nodata level leaves every sample invalid.
		settle(4);
		write_reg(REG_NODATA, 32'h7FFF_FFFF);
		height_plan = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF};
		feed();

		// Oversized grid, then rows and columns lowered below the position.
		settle(4);
		write_reg(REG_NUM_ROWS, size_word(11'd2047));
		write_reg(REG_NUM_COLS, size_word(11'd2047));
		write_reg(REG_NODATA, 32'hFFD8_F000);
		repeat (5) height_plan.push_back(near_floor());
		feed();
		settle(4);
		write_reg(REG_NUM_ROWS, size_word(11'd3));
		repeat (4) height_plan.push_back(near_floor());
		feed();
		settle(4);
		write_reg(REG_NUM_COLS, size_word(11'd2));
		repeat (3) height_plan.push_back(near_floor());
		feed();

		while (random_sent < RANDOM_ITEMS) begin
			settle(4);
			pop_steady <= ($urandom_range(0, 4) == 0);
			burst = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 2) == 0) begin
				size_pick = pick_size();
				// Rows may only grow mid-grid over entries already in the column store.
				if (at_col == '0 ||
					int'(size_pick > MAX_ROWS ? MAX_ROWS : size_pick) <= rows_covered) begin
					write_reg(REG_NUM_ROWS, size_word(size_pick));
				end
			end
			if ($urandom_range(0, 3) == 0) begin
				write_reg(REG_NUM_COLS, size_word(pick_size()));
			end
			if ($urandom_range(0, 2) == 0) begin
				k = $urandom_range(0, 9);
				if (k == 0) begin
					write_reg(REG_NODATA, 32'h8000_0000);
				end else if (k == 1) begin
					write_reg(REG_NODATA, 32'h7FFF_FFFF);
				end else if (k < 4) begin
					write_reg(REG_NODATA, $urandom());
				end else begin
					write_reg(REG_NODATA, 32'($urandom_range(0, 400000)) - 32'd200000);
				end
			end
			batch = $urandom_range(1, 40);
			repeat (batch) height_plan.push_back(random_height());
			feed();
			random_sent += batch;
		end

		settle(20);
		if (mismatches == 0 && pending == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[height_grid_triangulator.f]
rtl/hgt_pkg.sv
rtl/hgt_front.sv
rtl/hgt_queue.sv
rtl/hgt_back.sv
rtl/height_grid_triangulator.sv
test/triangle_checker.sv
test/testbench.sv
